// ===== design/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// Sized integer ALU package
// Beat types, opcodes and size helpers shared by the ALU pipeline.
// ----------------------------------------------------------------------------
package sia_pkg;

   localparam int WordBits = 64;
   localparam int DivSteps = WordBits;
   localparam int MulLine  = DivSteps - 2;

   localparam logic [5:0] OP_MOVE  = 6'd0;
   localparam logic [5:0] OP_CLR   = 6'd1;
   localparam logic [5:0] OP_BSWAP = 6'd2;
   localparam logic [5:0] OP_AND   = 6'd3;
   localparam logic [5:0] OP_OR    = 6'd4;
   localparam logic [5:0] OP_EOR   = 6'd5;
   localparam logic [5:0] OP_NOT   = 6'd6;
   localparam logic [5:0] OP_LSL   = 6'd7;
   localparam logic [5:0] OP_LSR   = 6'd8;
   localparam logic [5:0] OP_BCLR  = 6'd9;
   localparam logic [5:0] OP_BSET  = 6'd10;
   localparam logic [5:0] OP_EXT   = 6'd11;
   localparam logic [5:0] OP_ASL   = 6'd12;
   localparam logic [5:0] OP_ASR   = 6'd13;
   localparam logic [5:0] OP_ADD   = 6'd14;
   localparam logic [5:0] OP_SUB   = 6'd15;
   localparam logic [5:0] OP_NEG   = 6'd16;
   localparam logic [5:0] OP_MULS  = 6'd17;
   localparam logic [5:0] OP_MULU  = 6'd18;
   localparam logic [5:0] OP_DIVS  = 6'd19;
   localparam logic [5:0] OP_DIVU  = 6'd20;
   localparam logic [5:0] OP_BIZ   = 6'd21;
   localparam logic [5:0] OP_BNZ   = 6'd22;
   localparam logic [5:0] OP_BMI   = 6'd23;
   localparam logic [5:0] OP_BPL   = 6'd24;
   localparam logic [5:0] OP_BLT   = 6'd25;
   localparam logic [5:0] OP_BLE   = 6'd26;
   localparam logic [5:0] OP_BEQ   = 6'd27;
   localparam logic [5:0] OP_BGE   = 6'd28;
   localparam logic [5:0] OP_BGT   = 6'd29;
   localparam logic [5:0] OP_BNE   = 6'd30;
   localparam logic [5:0] OP_BBS   = 6'd31;
   localparam logic [5:0] OP_BBC   = 6'd32;
   localparam logic [5:0] OP_DBNZ  = 6'd33;

   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_WORD = 2'd1;
   localparam logic [1:0] SZ_LONG = 2'd2;
   localparam logic [1:0] SZ_QUAD = 2'd3;

   typedef struct packed {
      logic [5:0]  op;
      logic [1:0]  size;
      logic [1:0]  ext_from;
      logic [63:0] src;
      logic [63:0] dst;
   } sia_req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        writes;
      logic        taken;
      logic        fault;
   } sia_rsp_type;

   typedef enum logic [1:0] {
      SEL_SIMPLE,
      SEL_MUL,
      SEL_DIV
   } sia_sel_type;

   typedef struct packed {
      logic [63:0] dst;
      logic [63:0] val;
      logic [1:0]  size;
      sia_sel_type sel;
      logic        neg_q;
      logic        wr;
      logic        tk;
      logic        flt;
      logic        low_only;
   } sia_ctx_type;

   function automatic logic [63:0] size_mask(input logic [1:0] sz);
      logic [63:0] m;
      case (sz)
         SZ_BYTE: m = 64'h0000_0000_0000_00FF;
         SZ_WORD: m = 64'h0000_0000_0000_FFFF;
         SZ_LONG: m = 64'h0000_0000_FFFF_FFFF;
         default: m = '1;
      endcase
      return m;
   endfunction

   function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [1:0] sz);
      logic [63:0] r;
      case (sz)
         SZ_BYTE: r = {{56{v[7]}}, v[7:0]};
         SZ_WORD: r = {{48{v[15]}}, v[15:0]};
         SZ_LONG: r = {{32{v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

// ===== design/sized_integer_alu_and_branch_test.sv =====
// ----------------------------------------------------------------------------
// Sized integer ALU and branch test
// Executes one integer instruction per beat at byte, word, long or quad size.
//
// The req channel carries one instruction per beat: op, size, ext_from, src
// and dst. The rsp channel returns one beat per instruction, in order, with
// the new destination value, the write flag, the branch outcome and the
// divide-by-zero fault. Both channels use valid and ready.
// Every instruction runs through the same pipeline: an input register, a
// decode stage that finishes all operations but multiply and divide, then 64
// divider stages that produce one quotient bit each, with the multiplier and
// the other results carried alongside. One beat is accepted per cycle while
// the output buffer is not full.
// A two-entry output buffer decouples the pipeline from rsp_ready; when it
// is full the whole pipeline holds and req_ready drops, so nothing is lost.
// Reset empties the pipeline and the buffer.
// ----------------------------------------------------------------------------
module sized_integer_alu_and_branch_test import sia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sia_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sia_rsp_type rsp_payload
);

   logic        en;
   logic        f_valid;
   sia_ctx_type f_ctx;
   logic [63:0] mul_a, mul_b, div_n, div_d, prod, quot;

   logic        valid_ff [DivSteps];
   sia_ctx_type ctx_ff   [DivSteps];
   logic [63:0] mprod_ff [MulLine];

   sia_rsp_type buf_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   sia_ctx_type last_ctx;
   sia_rsp_type done;
   logic [63:0] v, m;

   assign en = count_ff != 2'd2;
   assign req_ready = en;

   sia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_beat   (req_payload),
      .out_valid (f_valid),
      .out_ctx   (f_ctx),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .div_n     (div_n),
      .div_d     (div_d)
   );

   sia_mul u_mul (
      .clock (clock),
      .en    (en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   sia_div u_div (
      .clock (clock),
      .en    (en),
      .n     (div_n),
      .d     (div_d),
      .q     (quot)
   );

   for (genvar k = 0; k < DivSteps; k++) begin : g_ctx
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= (k == 0) ? f_valid : valid_ff[(k == 0) ? 0 : k-1];
         end
         if (en) begin
            ctx_ff[k] <= (k == 0) ? f_ctx : ctx_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   for (genvar k = 0; k < MulLine; k++) begin : g_mprod
      always_ff @(posedge clock) begin
         if (en) begin
            mprod_ff[k] <= (k == 0) ? prod : mprod_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_comb begin
      last_ctx = ctx_ff[DivSteps-1];
      m = size_mask(last_ctx.size);
      case (last_ctx.sel)
         SEL_MUL: v = mprod_ff[MulLine-1];
         SEL_DIV: v = last_ctx.neg_q ? 64'd0 - quot : quot;
         default: v = last_ctx.val;
      endcase
      done.writes = last_ctx.wr;
      done.taken  = last_ctx.tk;
      done.fault  = last_ctx.flt;
      if (!last_ctx.wr) begin
         done.result = last_ctx.dst;
      end else if (last_ctx.low_only) begin
         done.result = (last_ctx.dst & ~m) | (v & m);
      end else begin
         done.result = v;
      end
   end

   assign push = en && valid_ff[DivSteps-1];
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= done;
      end
   end

   assign rsp_valid   = count_ff != 2'd0;
   assign rsp_payload = buf_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fault |-> !rsp_payload.writes && !rsp_payload.taken)
      else $error("fault beat also writes or branches");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== design/sia_front.sv =====
// ----------------------------------------------------------------------------
// Sized integer ALU front end
// Input register, operand decode and all operations but multiply and divide.
// ----------------------------------------------------------------------------
module sia_front import sia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  sia_req_type in_beat,
   output logic        out_valid,
   output sia_ctx_type out_ctx,
   output logic [63:0] mul_a,
   output logic [63:0] mul_b,
   output logic [63:0] div_n,
   output logic [63:0] div_d
);

   logic        p1_valid_ff;
   sia_req_type p1_ff;
   logic        p2_valid_ff;
   sia_ctx_type ctx_ff, ctx_in;
   logic [63:0] div_n_ff, div_n_in, div_d_ff, div_d_in;
   logic [63:0] mul_a_ff, mul_b_ff;

   logic [63:0] src, dst, m, sa, da, val;
   logic [5:0]  cnt;
   logic        bit_sel;

   always_comb begin
      src = p1_ff.src;
      dst = p1_ff.dst;
      m   = size_mask(p1_ff.size);
      cnt = src[5:0] & {p1_ff.size == SZ_QUAD, p1_ff.size[1], p1_ff.size != SZ_BYTE, 3'b111};
      sa  = sign_ext(src, p1_ff.size);
      da  = sign_ext(dst, p1_ff.size);
      bit_sel = dst[cnt];
      val = '0;
      ctx_in = '0;
      ctx_in.dst = dst;
      ctx_in.size = p1_ff.size;
      ctx_in.sel = SEL_SIMPLE;
      ctx_in.wr = 1'b1;
      ctx_in.low_only = 1'b1;
      div_n_in = da[63] ? 64'd0 - da : da;
      div_d_in = sa[63] ? 64'd0 - sa : sa;
      case (p1_ff.op)
         OP_MOVE:  val = src;
         OP_CLR:   val = '0;
         OP_BSWAP: begin
            case (p1_ff.size)
               SZ_BYTE: val = src;
               SZ_WORD: val = {48'd0, src[7:0], src[15:8]};
               SZ_LONG: val = {32'd0, src[7:0], src[15:8], src[23:16], src[31:24]};
               default: val = {src[7:0], src[15:8], src[23:16], src[31:24],
                               src[39:32], src[47:40], src[55:48], src[63:56]};
            endcase
         end
         OP_AND:   val = dst & src;
         OP_OR:    val = dst | src;
         OP_EOR:   val = dst ^ src;
         OP_NOT:   val = ~src;
         OP_LSL, OP_ASL: val = (dst & m) << cnt;
         OP_LSR:   val = (dst & m) >> cnt;
         OP_BCLR:  val = dst & ~(64'd1 << cnt);
         OP_BSET:  val = dst | (64'd1 << cnt);
         OP_EXT:   val = sign_ext(src, p1_ff.ext_from);
         OP_ASR:   val = $unsigned($signed(da) >>> cnt);
         OP_ADD:   val = dst + src;
         OP_SUB:   val = dst - src;
         OP_NEG:   val = 64'd0 - src;
         OP_MULS, OP_MULU: ctx_in.sel = SEL_MUL;
         OP_DIVS: begin
            ctx_in.sel = SEL_DIV;
            ctx_in.neg_q = da[63] ^ sa[63];
            if (div_d_in == 64'd0) begin
               ctx_in.wr = 1'b0;
               ctx_in.flt = 1'b1;
            end
         end
         OP_DIVU: begin
            ctx_in.sel = SEL_DIV;
            div_n_in = dst & m;
            div_d_in = src & m;
            if (div_d_in == 64'd0) begin
               ctx_in.wr = 1'b0;
               ctx_in.flt = 1'b1;
            end
         end
         OP_DBNZ: begin
            val = {dst[63:32], dst[31:0] - 32'd1};
            ctx_in.tk = val[31:0] != 32'd0;
            ctx_in.low_only = 1'b0;
         end
         default: begin
            ctx_in.wr = 1'b0;
            case (p1_ff.op)
               OP_BIZ:  ctx_in.tk = (dst & m) == 64'd0;
               OP_BNZ:  ctx_in.tk = (dst & m) != 64'd0;
               OP_BMI:  ctx_in.tk = da[63];
               OP_BPL:  ctx_in.tk = !da[63] && da != 64'd0;
               OP_BLT:  ctx_in.tk = $signed(sa) < $signed(da);
               OP_BLE:  ctx_in.tk = $signed(sa) <= $signed(da);
               OP_BEQ:  ctx_in.tk = sa == da;
               OP_BGE:  ctx_in.tk = $signed(sa) >= $signed(da);
               OP_BGT:  ctx_in.tk = $signed(sa) > $signed(da);
               OP_BNE:  ctx_in.tk = sa != da;
               OP_BBS:  ctx_in.tk = bit_sel;
               OP_BBC:  ctx_in.tk = !bit_sel;
               default: ctx_in.tk = 1'b0;
            endcase
         end
      endcase
      ctx_in.val = val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         p1_ff    <= in_beat;
         ctx_ff   <= ctx_in;
         div_n_ff <= div_n_in;
         div_d_ff <= div_d_in;
         mul_a_ff <= dst;
         mul_b_ff <= src;
      end
   end

   assign out_valid = p2_valid_ff;
   assign out_ctx   = ctx_ff;
   assign mul_a     = mul_a_ff;
   assign mul_b     = mul_b_ff;
   assign div_n     = div_n_ff;
   assign div_d     = div_d_ff;

endmodule

// ===== design/sia_mul.sv =====
// ----------------------------------------------------------------------------
// Sized integer ALU multiplier
// Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
// ----------------------------------------------------------------------------
module sia_mul import sia_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] prod
);

   logic [63:0] ll_ff;
   logic [31:0] lh_ff, hl_ff;
   logic [63:0] prod_ff;
   logic [63:0] lh_full, hl_full;

   assign lh_full = a[31:0] * b[63:32];
   assign hl_full = a[63:32] * b[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff   <= a[31:0] * b[31:0];
         lh_ff   <= lh_full[31:0];
         hl_ff   <= hl_full[31:0];
         prod_ff <= ll_ff + {lh_ff + hl_ff, 32'd0};
      end
   end

   assign prod = prod_ff;

endmodule

// ===== design/sia_div.sv =====
// ----------------------------------------------------------------------------
// Sized integer ALU divider
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module sia_div import sia_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] n,
   input  logic [63:0] d,
   output logic [63:0] q
);

   logic [63:0] rem_ff [DivSteps];
   logic [63:0] nq_ff  [DivSteps];
   logic [63:0] d_ff   [DivSteps];

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [63:0] rem_prev, nq_prev, d_prev;
      logic [64:0] shifted, diff;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = n;
         assign d_prev   = d;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign d_prev   = d_ff[k-1];
      end

      assign shifted = {rem_prev, nq_prev[63]};
      assign diff    = shifted - {1'b0, d_prev};
      assign ge      = shifted >= {1'b0, d_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[63:0] : shifted[63:0];
            nq_ff[k]  <= {nq_prev[62:0], ge};
            d_ff[k]   <= d_prev;
         end
      end
   end

   assign q = nq_ff[DivSteps-1];

endmodule

// ===== dv/sized_integer_alu_and_branch_test_tb.sv =====
// ----------------------------------------------------------------------------
// Sized integer ALU and branch test bench
// Drives instructions over the req channel, predicts each rsp beat from a given
// expected value or an independent model of the sized ALU, and compares all fields in order.
// ----------------------------------------------------------------------------
module sized_integer_alu_and_branch_test_tb;
   import sia_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DrainCycles = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   sia_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   sia_rsp_type rsp_payload;

   sia_rsp_type pending_rsp[$];
   int          error_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   typedef struct {
      sia_req_type req;
      logic        known;
      sia_rsp_type rsp;
   } directed_row_type;

   sized_integer_alu_and_branch_test dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [63:0] mask_of(input logic [1:0] sz);
      return (sz == SZ_QUAD) ? '1 : ((64'd1 << (8 << sz)) - 64'd1);
   endfunction

   function automatic logic [63:0] widen(input logic [63:0] v, input logic [1:0] sz);
      logic [63:0] m;
      m = mask_of(sz);
      if (sz == SZ_QUAD) return v;
      return v[(8 << sz) - 1] ? ((v & m) | ~m) : (v & m);
   endfunction

   function automatic sia_rsp_type alu_outcome(input sia_req_type r);
      sia_rsp_type o;
      logic [63:0] m, val, sa, da, ma, mb, lo;
      logic        wr, tk, flt, low_only, bitv;
      int          cnt;
      m = mask_of(r.size);
      cnt = int'(r.src & ((64'd8 << r.size) - 1));
      sa = widen(r.src, r.size);
      da = widen(r.dst, r.size);
      val = '0;
      wr = 1'b1;
      tk = 1'b0;
      flt = 1'b0;
      low_only = 1'b1;
      bitv = r.dst[cnt];
      case (r.op)
         OP_MOVE: val = r.src;
         OP_CLR: val = '0;
         OP_BSWAP: begin
            for (int i = 0; i < (1 << r.size); i++) val = (val << 8) | r.src[8*i +: 8];
         end
         OP_AND: val = r.dst & r.src;
         OP_OR: val = r.dst | r.src;
         OP_EOR: val = r.dst ^ r.src;
         OP_NOT: val = ~r.src;
         OP_LSL, OP_ASL: val = (r.dst & m) << cnt;
         OP_LSR: val = (r.dst & m) >> cnt;
         OP_BCLR: val = r.dst & ~(64'd1 << cnt);
         OP_BSET: val = r.dst | (64'd1 << cnt);
         OP_EXT: val = widen(r.src, r.ext_from);
         OP_ASR: val = $signed(da) >>> cnt;
         OP_ADD: val = r.dst + r.src;
         OP_SUB: val = r.dst - r.src;
         OP_NEG: val = -r.src;
         OP_MULS, OP_MULU: val = r.dst * r.src;
         OP_DIVS: begin
            ma = da[63] ? -da : da;
            mb = sa[63] ? -sa : sa;
            if (mb == 0) begin
               wr = 1'b0;
               flt = 1'b1;
            end else begin
               val = ma / mb;
               if (da[63] != sa[63]) val = -val;
            end
         end
         OP_DIVU: begin
            if ((r.src & m) == 0) begin
               wr = 1'b0;
               flt = 1'b1;
            end else val = (r.dst & m) / (r.src & m);
         end
         OP_DBNZ: begin
            lo = {32'd0, r.dst[31:0] - 32'd1};
            val = {r.dst[63:32], lo[31:0]};
            tk = lo != 0;
            low_only = 1'b0;
         end
         default: begin
            wr = 1'b0;
            case (r.op)
               OP_BIZ: tk = (r.dst & m) == 0;
               OP_BNZ: tk = (r.dst & m) != 0;
               OP_BMI: tk = $signed(da) < 0;
               OP_BPL: tk = $signed(da) > 0;
               OP_BLT: tk = $signed(sa) < $signed(da);
               OP_BLE: tk = $signed(sa) <= $signed(da);
               OP_BEQ: tk = sa == da;
               OP_BGE: tk = $signed(sa) >= $signed(da);
               OP_BGT: tk = $signed(sa) > $signed(da);
               OP_BNE: tk = sa != da;
               OP_BBS: tk = bitv;
               OP_BBC: tk = !bitv;
               default: tk = 1'b0;
            endcase
         end
      endcase
      if (!wr) o.result = r.dst;
      else if (low_only) o.result = (r.dst & ~m) | (val & m);
      else o.result = val;
      o.writes = wr;
      o.taken = tk;
      o.fault = flt;
      return o;
   endfunction

   function automatic sia_req_type make_req(input logic [5:0] op, input logic [1:0] sz,
                                            input logic [1:0] ef, input logic [63:0] s,
                                            input logic [63:0] d);
      sia_req_type r;
      r.op = op;
      r.size = sz;
      r.ext_from = ef;
      r.src = s;
      r.dst = d;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = '1;
         2: v = 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
         3: v = v & 64'hFF;
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_beat(input sia_req_type r, input logic known, input sia_rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      pending_rsp.push_back(known ? want : alu_outcome(r));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      sia_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected rsp beat: result %h", rsp_payload.result);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.result !== want.result) begin
               $error("result: expected %h, got %h", want.result, rsp_payload.result);
               error_count++;
            end
            if (rsp_payload.writes !== want.writes) begin
               $error("writes: expected %b, got %b", want.writes, rsp_payload.writes);
               error_count++;
            end
            if (rsp_payload.taken !== want.taken) begin
               $error("taken: expected %b, got %b", want.taken, rsp_payload.taken);
               error_count++;
            end
            if (rsp_payload.fault !== want.fault) begin
               $error("fault: expected %b, got %b", want.fault, rsp_payload.fault);
               error_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      sia_req_type r;
      sia_rsp_type none;
      logic [63:0] a;
      logic [63:0] b;
      int n;
      none = '0;
      error_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      a = 64'h1122_3344_5566_7788;
      rows.push_back('{make_req(OP_MOVE, SZ_BYTE, SZ_BYTE, '1, '0), 1'b1,
                      '{64'hFF, 1'b1, 1'b0, 1'b0}});
      rows.push_back('{make_req(OP_CLR, SZ_QUAD, SZ_BYTE, '0, '1), 1'b1,
                      '{64'h0, 1'b1, 1'b0, 1'b0}});
      rows.push_back('{make_req(OP_BSWAP, SZ_QUAD, SZ_BYTE, a, '0), 1'b1,
                      '{64'h8877_6655_4433_2211, 1'b1, 1'b0, 1'b0}});
      rows.push_back('{make_req(OP_BSWAP, SZ_BYTE, SZ_BYTE, a, '1), 1'b0, none});
      rows.push_back('{make_req(OP_DIVU, SZ_LONG, SZ_BYTE, 64'hFFFF_FFFF_0000_0000, a), 1'b1,
                      '{a, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{make_req(OP_DIVS, SZ_QUAD, SZ_BYTE, '0, a), 1'b1,
                      '{a, 1'b0, 1'b0, 1'b1}});
      rows.push_back('{make_req(OP_DIVS, SZ_QUAD, SZ_BYTE, '1, 64'h8000_0000_0000_0000), 1'b1,
                      '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0}});
      rows.push_back('{make_req(OP_DIVS, SZ_BYTE, SZ_BYTE, 64'hFF, 64'h80), 1'b0, none});
      rows.push_back('{make_req(OP_DBNZ, SZ_BYTE, SZ_BYTE, '0, 64'h5_0000_0001), 1'b1,
                      '{64'h5_0000_0000, 1'b1, 1'b0, 1'b0}});
      rows.push_back('{make_req(OP_DBNZ, SZ_QUAD, SZ_BYTE, '0, 64'h5_0000_0000), 1'b1,
                      '{64'h5_FFFF_FFFF, 1'b1, 1'b1, 1'b0}});
      rows.push_back('{make_req(6'd63, SZ_QUAD, SZ_QUAD, '1, a), 1'b1,
                      '{a, 1'b0, 1'b0, 1'b0}});
      rows.push_back('{make_req(6'd34, SZ_BYTE, SZ_BYTE, '1, a), 1'b1,
                      '{a, 1'b0, 1'b0, 1'b0}});
      rows.push_back('{make_req(OP_EXT, SZ_QUAD, SZ_WORD, 64'h8000, '0), 1'b0, none});
      rows.push_back('{make_req(OP_EXT, SZ_WORD, SZ_QUAD, '1, '0), 1'b0, none});
      rows.push_back('{make_req(OP_ASR, SZ_WORD, SZ_BYTE, 64'h1F, 64'h8000), 1'b0, none});
      rows.push_back('{make_req(OP_LSL, SZ_QUAD, SZ_BYTE, 64'h3F, '1), 1'b0, none});
      rows.push_back('{make_req(OP_BSET, SZ_QUAD, SZ_BYTE, 64'h3F, '0), 1'b0, none});
      rows.push_back('{make_req(OP_BPL, SZ_BYTE, SZ_BYTE, '0, 64'h0), 1'b0, none});
      rows.push_back('{make_req(OP_BMI, SZ_LONG, SZ_BYTE, '0, 64'h8000_0000), 1'b0, none});
      rows.push_back('{make_req(OP_BLT, SZ_WORD, SZ_BYTE, 64'h8000, 64'h7FFF), 1'b0, none});
      rows.push_back('{make_req(OP_BBS, SZ_QUAD, SZ_BYTE, 64'h3F, '1), 1'b0, none});
      rows.push_back('{make_req(OP_MULS, SZ_QUAD, SZ_BYTE, '1, '1), 1'b0, none});
      rows.push_back('{make_req(OP_NEG, SZ_LONG, SZ_BYTE, 64'h8000_0000, '1), 1'b0, none});
      foreach (rows[i]) begin
         row = rows[i];
         send_beat(row.req, row.known, row.rsp);
      end
      for (int op = OP_MOVE; op <= OP_DBNZ; op++) begin
         send_beat(make_req(6'(op), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            rand64(), rand64()), 1'b0, none);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 81 : 0;
         recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 23 : 0;
         for (n = 0; n < 360; n++) begin
            a = rand64();
            b = rand64();
            r = make_req(6'($urandom_range(0, 99) < 95 ? $urandom_range(0, 33)
                            : $urandom_range(34, 63)),
                         2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), a, b);
            send_beat(r, 1'b0, none);
            if (n == 180) wait_drained();
         end
      end

      fork
         wait_drained();
         begin
            repeat (200000) @(posedge clock);
         end
      join_any
      disable fork;
      if (pending_rsp.size() != 0) begin
         $display("FAILED: results differ");
         $finish;
      end
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/sia_pkg.sv
design/sia_front.sv
design/sia_mul.sv
design/sia_div.sv
design/sized_integer_alu_and_branch_test.sv
dv/sized_integer_alu_and_branch_test_tb.sv
